### hw/rtl/xsa_pkg.sv
// ============================================================================
// XXH3 stripe accumulator package
// Shared types, sizes and operation codes for the stripe accumulator.
// ============================================================================
package xsa_pkg;

  // Accumulator organization
  localparam int ACC_LANES  = 8;
  localparam int PAIR_COUNT = ACC_LANES / 2;
  localparam int PAIR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  // Result queue sizing
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Scramble constants
  localparam int SCRAMBLE_SHIFT = 47;
  localparam logic [31:0] MIX_PRIME_RESET = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_SCRAMBLE = 2'd1,
    OP_LOAD     = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  lane_pair;
    logic [63:0] data_even;
    logic [63:0] data_odd;
    logic [63:0] key_even;
    logic [63:0] key_odd;
  } in_item_t;

  // Also the layout of one accumulator memory word
  typedef struct packed {
    logic [63:0] acc_even;
    logic [63:0] acc_odd;
  } out_item_t;

  // Fold the requested pair onto the implemented pairs
  function automatic logic [PAIR_W-1:0] pair_index(input logic [1:0] lane_pair);
    int p;
    p = int'(lane_pair) % PAIR_COUNT;
    return PAIR_W'(p);
  endfunction

endpackage

### hw/rtl/xsa_acc_ram.sv
// ============================================================================
// Accumulator pair memory
// One 128-bit word per lane pair, synchronous read with registered data.
// Per-entry valid bits make unwritten pairs read as zero after reset.
// ============================================================================
module xsa_acc_ram
  import xsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [PAIR_W-1:0] rd_addr,
  output out_item_t         rd_data,
  input  logic              wr_en,
  input  logic [PAIR_W-1:0] wr_addr,
  input  out_item_t         wr_data
);

  out_item_t              mem [PAIR_COUNT];
  logic [PAIR_COUNT-1:0]  vld_r;
  out_item_t              rd_q_r;
  logic                   rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track which pairs hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### hw/rtl/xsa_lane_unit.sv
// ============================================================================
// Lane datapath
// Accumulate, scramble, load and read for one lane over three stages:
// product of the data/key halves, scramble partial products, final add.
// ============================================================================
module xsa_lane_unit
  import xsa_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] prime,
  input  op_t         s0_op,
  input  logic [63:0] s0_data,
  input  logic [63:0] s0_key,
  input  logic [63:0] s0_other,
  input  logic [63:0] s1_acc,
  output logic [63:0] result
);

  logic [63:0] dk;
  logic [63:0] prod;

  op_t         s1_op_r;
  logic [63:0] s1_prod_r;
  logic [63:0] s1_other_r;
  logic [63:0] s1_data_r;
  logic [63:0] s1_key_r;

  logic [63:0] mixed;
  logic [63:0] part_lo;
  logic [31:0] part_hi;

  op_t         s2_op_r;
  logic [63:0] s2_acc_r;
  logic [63:0] s2_addend_r;
  logic [63:0] s2_lo_r;
  logic [31:0] s2_hi_r;
  logic [63:0] s2_data_r;

  // Stage 0: low half times high half of data xor key
  assign dk   = s0_data ^ s0_key;
  assign prod = dk[31:0] * dk[63:32];

  always_ff @(posedge clk) begin
    s1_op_r    <= s0_op;
    s1_prod_r  <= prod;
    s1_other_r <= s0_other;
    s1_data_r  <= s0_data;
    s1_key_r   <= s0_key;
  end

  // Stage 1: fold and split the 64x32 scramble product into two halves
  assign mixed   = (s1_acc ^ (s1_acc >> SCRAMBLE_SHIFT)) ^ s1_key_r;
  assign part_lo = mixed[31:0] * prime;
  assign part_hi = mixed[63:32] * prime;

  always_ff @(posedge clk) begin
    s2_op_r     <= s1_op_r;
    s2_acc_r    <= s1_acc;
    s2_addend_r <= s1_prod_r + s1_other_r;
    s2_lo_r     <= part_lo;
    s2_hi_r     <= part_hi;
    s2_data_r   <= s1_data_r;
  end

  // Stage 2: select the new accumulator value
  always_comb begin
    unique case (s2_op_r)
      OP_ACCUM:    result = s2_acc_r + s2_addend_r;
      OP_SCRAMBLE: result = s2_lo_r + {s2_hi_r, 32'd0};
      OP_LOAD:     result = s2_data_r;
      OP_READ:     result = s2_acc_r;
      default:     result = s2_acc_r;
    endcase
  end

endmodule

### hw/rtl/xsa_out_fifo.sv
// ============================================================================
// Result queue
// Small register queue between the write-back stage and the result channel.
// Space is reserved at input accept, so a push always finds a free slot.
// ============================================================================
module xsa_out_fifo
  import xsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_item_t            push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output out_item_t            head,
  output logic [OUT_CNT_W-1:0] count
);

  out_item_t              slot_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r;
  logic [OUT_PTR_W-1:0]   rd_ptr_r;
  logic [OUT_CNT_W-1:0]   count_r;
  logic                   do_pop;

  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // A push never lands on a full queue unless a pop frees a slot in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != OUT_CNT_W'(OUT_DEPTH)) || do_pop)
    else $error("result queue overflow");

endmodule

### hw/rtl/xxh3_stripe_accumulator.sv
// ============================================================================
// XXH3 stripe accumulator
// Eight 64-bit accumulators held as lane pairs in a memory; each item updates
// one pair by accumulate, scramble, load or read and returns the pair.
// ============================================================================
// Pipeline: read and multiply, then add, write-back and result queue push in stage 2.
// Throughput: one item per cycle; an item on the same pair as the item just
//   before it waits while that item is still in stage 1.
//   Input stalls while four items are in flight behind a held result side.
// Reset: synchronous; clears the pair valid bits so all accumulators read zero,
//   empties the pipeline and result queue, and restores mix_prime.
module xxh3_stripe_accumulator
  import xsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]          prime_r;

  logic                 accept;
  logic                 hazard;
  logic [PAIR_W-1:0]    in_idx;
  logic [OUT_CNT_W:0]   occupancy;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  logic                 s1_v_r;
  logic [PAIR_W-1:0]    s1_pair_r;
  logic                 s2_v_r;
  logic [PAIR_W-1:0]    s2_pair_r;

  logic                 wb_v_r;
  logic [PAIR_W-1:0]    wb_pair_r;
  out_item_t            wb_data_r;

  out_item_t            ram_rd;
  out_item_t            s1_acc;
  out_item_t            result;
  logic [63:0]          res_even;
  logic [63:0]          res_odd;
  logic                 fwd;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= MIX_PRIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prime_r <= cfg_data;
    end
  end

  // Admit an item when queue space is reserved and the pair is not in stage 1
  assign in_idx    = pair_index(in_data.lane_pair);
  assign hazard    = s1_v_r && (s1_pair_r == in_idx);
  assign occupancy = {{OUT_CNT_W{1'b0}}, s1_v_r} + {{OUT_CNT_W{1'b0}}, s2_v_r}
                   + {1'b0, fifo_cnt};
  assign in_ready  = (occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH)) && !hazard;
  assign accept    = in_valid && in_ready;

  // Advance pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      wb_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pair_r <= in_idx;
    s2_pair_r <= s1_pair_r;
    wb_pair_r <= s2_pair_r;
    wb_data_r <= result;
  end

  // Accumulator memory: read at accept, write back from stage 2
  xsa_acc_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (ram_rd),
    .wr_en   (s2_v_r),
    .wr_addr (s2_pair_r),
    .wr_data (result)
  );

  // Forward the value written on the same edge as this item's read
  assign fwd    = wb_v_r && (wb_pair_r == s1_pair_r);
  assign s1_acc = fwd ? wb_data_r : ram_rd;

  // Lane datapaths
  xsa_lane_unit u_lane_even (
    .clk      (clk),
    .prime    (prime_r),
    .s0_op    (op_t'(in_data.opcode)),
    .s0_data  (in_data.data_even),
    .s0_key   (in_data.key_even),
    .s0_other (in_data.data_odd),
    .s1_acc   (s1_acc.acc_even),
    .result   (res_even)
  );

  xsa_lane_unit u_lane_odd (
    .clk      (clk),
    .prime    (prime_r),
    .s0_op    (op_t'(in_data.opcode)),
    .s0_data  (in_data.data_odd),
    .s0_key   (in_data.key_odd),
    .s0_other (in_data.data_even),
    .s1_acc   (s1_acc.acc_odd),
    .result   (res_odd)
  );

  assign result = {res_even, res_odd};

  // Result queue toward the output channel
  xsa_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (result),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (fifo_cnt)
  );

  // Adjacent items in stages 1 and 2 never share a pair
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r) |-> (s1_pair_r != s2_pair_r))
    else $error("same pair in consecutive stages");

  // Items in flight never exceed the reserved queue space
  assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("in-flight count exceeds queue depth");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// XXH3 stripe accumulator testbench
// Drives accumulate, scramble, load and read items into the stripe
// accumulator: first a short directed table, then random phases under
// several mix_prime settings. Each returned pair is checked field by field
// against a typed row's pair or an in-bench model of the eight accumulators.
// ----------------------------------------------------------------------------
module testbench;
  import xsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 200;
  localparam int          LONG_HOLD     = 80;
  localparam int          SETTLE_CYCLES = 10;
  localparam logic [63:0] ONES          = '1;
  localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] K1            = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] K2            = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] SQ_ONES       = 64'hFFFF_FFFE_0000_0001;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the block state
  logic [63:0] acc_shadow [ACC_LANES];
  logic [31:0] prime_shadow;
  out_item_t   pending_pairs [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;
  bit  sender_burst = 1'b0;
  bit  long_hold_req = 1'b0;

  xxh3_stripe_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Multiply the halves of data^key and fold in the other lane's word
  function automatic logic [63:0] accum_lane(logic [63:0] acc, logic [63:0] data,
                                             logic [63:0] key, logic [63:0] other);
    logic [63:0] dk;
    logic [63:0] prod;
    dk   = data ^ key;
    prod = {32'b0, dk[31:0]} * {32'b0, dk[63:32]};
    return acc + prod + other;
  endfunction

  function automatic logic [63:0] scramble_lane(logic [63:0] acc, logic [63:0] key);
    logic [63:0] mixed;
    mixed = (acc ^ (acc >> SCRAMBLE_SHIFT)) ^ key;
    return mixed * {32'b0, prime_shadow};
  endfunction

  // Apply one item to the shadow accumulators and return the pair after it
  function automatic out_item_t pair_after_op(in_item_t it);
    int        ie;
    int        io;
    logic [63:0] ev;
    logic [63:0] od;
    out_item_t res;
    ie = (int'(it.lane_pair) % PAIR_COUNT) * 2;
    io = ie + 1;
    ev = acc_shadow[ie];
    od = acc_shadow[io];
    case (op_t'(it.opcode))
      OP_ACCUM: begin
        acc_shadow[ie] = accum_lane(ev, it.data_even, it.key_even, it.data_odd);
        acc_shadow[io] = accum_lane(od, it.data_odd, it.key_odd, it.data_even);
      end
      OP_SCRAMBLE: begin
        acc_shadow[ie] = scramble_lane(ev, it.key_even);
        acc_shadow[io] = scramble_lane(od, it.key_odd);
      end
      OP_LOAD: begin
        acc_shadow[ie] = it.data_even;
        acc_shadow[io] = it.data_odd;
      end
      default: begin
      end
    endcase
    res.acc_even = acc_shadow[ie];
    res.acc_odd  = acc_shadow[io];
    return res;
  endfunction

  function automatic stim_row_t row(op_t op, logic [1:0] pair, logic [63:0] de,
                                    logic [63:0] dodd, logic [63:0] ke, logic [63:0] ko,
                                    bit typed, logic [63:0] we, logic [63:0] wo);
    stim_row_t r;
    r.item.opcode    = op;
    r.item.lane_pair = pair;
    r.item.data_even = de;
    r.item.data_odd  = dodd;
    r.item.key_even  = ke;
    r.item.key_odd   = ko;
    r.typed          = typed;
    r.want.acc_even  = we;
    r.want.acc_odd   = wo;
    return r;
  endfunction

  // Mostly random words, with zero, all ones and single bits mixed in
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ONES;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode    = 2'($urandom_range(0, 3));
    it.lane_pair = 2'($urandom_range(0, 3));
    it.data_even = rand_word();
    it.data_odd  = rand_word();
    it.key_even  = rand_word();
    it.key_odd   = rand_word();
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then log its expected pair
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = (steady_flow || sender_burst) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = pair_after_op(it);
    pending_pairs.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every expected pair has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_prime(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    prime_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    stim_row_t   dir_rows [$];
    logic [31:0] primes [6];
    out_item_t   none;
    none = '0;
    for (int i = 0; i < ACC_LANES; i++) acc_shadow[i] = '0;
    prime_shadow = MIX_PRIME_RESET;

    // Directed table; typed rows carry a hand-checked pair
    dir_rows.push_back(row(OP_READ,     2'd0, ONES, ONES, ONES, ONES, 1, '0, '0));
    dir_rows.push_back(row(OP_READ,     2'd3, K1, K2, K2, K1, 1, '0, '0));
    dir_rows.push_back(row(OP_LOAD,     2'd1, ONES, ONES, K1, K2, 1, ONES, ONES));
    dir_rows.push_back(row(OP_READ,     2'd1, '0, '0, K1, K1, 1, ONES, ONES));
    dir_rows.push_back(row(OP_ACCUM,    2'd0, ONES, ONES, '0, '0, 1,
                           64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFE_0000_0000));
    dir_rows.push_back(row(OP_ACCUM,    2'd0, K1, K2, K1, K2, 0, '0, '0));
    dir_rows.push_back(row(OP_ACCUM,    2'd0, K1, K2, '0, '0, 0, '0, '0));
    dir_rows.push_back(row(OP_SCRAMBLE, 2'd3, ONES, ONES, '0, '0, 1, '0, '0));
    dir_rows.push_back(row(OP_SCRAMBLE, 2'd1, K1, K2, ONES, ONES, 0, '0, '0));
    dir_rows.push_back(row(OP_LOAD,     2'd2, TOP_BIT, 64'd1, ONES, ONES, 1, TOP_BIT, 64'd1));
    dir_rows.push_back(row(OP_SCRAMBLE, 2'd2, '0, '0, '0, '0, 0, '0, '0));
    dir_rows.push_back(row(OP_SCRAMBLE, 2'd2, ONES, K1, K2, K1, 0, '0, '0));
    dir_rows.push_back(row(OP_ACCUM,    2'd3, 64'hFFFF_FFFF_0000_0000,
                           64'h0000_0000_FFFF_FFFF, '0, '0, 1,
                           64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000));
    dir_rows.push_back(row(OP_READ,     2'd2, K2, K2, '0, '0, 0, '0, '0));
    dir_rows.push_back(row(OP_ACCUM,    2'd1, K2, K1, K1, ONES, 0, '0, '0));
    dir_rows.push_back(row(OP_READ,     2'd0, '0, '0, '0, '0, 0, '0, '0));
    dir_rows.push_back(row(OP_LOAD,     2'd3, '0, '0, ONES, ONES, 1, '0, '0));
    dir_rows.push_back(row(OP_ACCUM,    2'd3, ONES, '0, '0, ONES, 1,
                           SQ_ONES, 64'hFFFF_FFFE_0000_0000));
    dir_rows.push_back(row(OP_READ,     2'd3, ONES, ONES, ONES, ONES, 1,
                           SQ_ONES, 64'hFFFF_FFFE_0000_0000));

    primes = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h1, MIX_PRIME_RESET, $urandom};

    // Hold reset low, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, one per prime setting
    foreach (primes[p]) begin
      drain();
      write_prime(primes[p]);
      steady_flow  = (p == 2);
      sender_burst = (p == 3) || (p == 5);
      if (sender_burst) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sender_burst && n == PHASE_ITEMS / 2) sender_burst = 1'b0;
        send_item(rand_item(), 0, none);
      end
      steady_flow  = 1'b0;
      sender_burst = 1'b0;
    end

    drain();
    if (pending_pairs.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, with one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 10);
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each transfer on the result side with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result even=%h odd=%h", $time,
                 out_data.acc_even, out_data.acc_odd);
      end else begin
        want = pending_pairs.pop_front();
        if (out_data.acc_even !== want.acc_even) begin
          mismatch_count++;
          $display("%0t: acc_even expected %h got %h", $time,
                   want.acc_even, out_data.acc_even);
        end
        if (out_data.acc_odd !== want.acc_odd) begin
          mismatch_count++;
          $display("%0t: acc_odd expected %h got %h", $time,
                   want.acc_odd, out_data.acc_odd);
        end
      end
    end
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_pairs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
hw/rtl/xsa_pkg.sv
hw/rtl/xsa_acc_ram.sv
hw/rtl/xsa_lane_unit.sv
hw/rtl/xsa_out_fifo.sv
hw/rtl/xxh3_stripe_accumulator.sv
tb/sv/testbench.sv
